// ===== design/gbc_pkg.sv =====
// Shared types, widths and helpers for the gyro bias calibration and rate filter.
// Used by gbc_div and by the top level gyro_bias_calib_ema_filter.
`timescale 1ns / 1ps

package gbc_pkg;

  localparam int RAW_W   = 16;   // raw gyro reading
  localparam int RATE_W  = 20;   // scaled and filtered rate
  localparam int INV_W   = 16;   // inverse sensitivity register
  localparam int ALPHA_W = 9;    // filter weight register
  localparam int CNT_W   = 10;   // calibration sample count
  localparam int SUM_W   = 32;   // calibration running sum
  localparam int DIVR_W  = CNT_W + 1;
  localparam int WIDE_W  = 40;   // working width for products and accumulations
  localparam int EMA_SHIFT = 8;  // filter weight is Q1.8

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  localparam logic signed [WIDE_W-1:0] RATE_MAX = WIDE_W'(524287);
  localparam logic signed [WIDE_W-1:0] RATE_MIN = -WIDE_W'(524288);

  // Configuration register indexes.
  localparam logic [1:0] REG_INV_SENS  = 2'd0;
  localparam logic [1:0] REG_ALPHA     = 2'd1;
  localparam logic [1:0] REG_CALIB_CNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_BIAS,
    ST_ACCUM,
    ST_DIV,
    ST_EMA,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [DIVR_W-1:0]       divisor;
  } div_req_t;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [WIDE_W-1:0] v);
    logic signed [RATE_W-1:0] r;
    if (v > RATE_MAX) begin
      r = RATE_MAX[RATE_W-1:0];
    end else if (v < RATE_MIN) begin
      r = RATE_MIN[RATE_W-1:0];
    end else begin
      r = v[RATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gbc_div.sv =====
// Iterative signed divider for the bias average, one quotient bit per cycle.
// Depends on gbc_pkg for widths and the request struct.
`timescale 1ns / 1ps

module gbc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gbc_pkg::div_req_t                req_i,
  output logic                             done_o,
  output logic signed [gbc_pkg::SUM_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(gbc_pkg::SUM_W);

  logic                         busy_q;
  logic                         done_q;
  logic [STEP_W-1:0]            step_q;
  logic [gbc_pkg::SUM_W-1:0]    mag_q;
  logic [gbc_pkg::DIVR_W-1:0]   rem_q;
  logic [gbc_pkg::DIVR_W-1:0]   divr_q;
  logic                         neg_q;

  logic [gbc_pkg::DIVR_W:0]     rem_sh;
  logic                         q_bit;
  logic [gbc_pkg::DIVR_W-1:0]   rem_d;

  // Restoring division on the magnitude; the sign is applied at the end so the
  // quotient truncates toward zero.
  always_comb begin
    rem_sh = {rem_q, mag_q[gbc_pkg::SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, divr_q});
    if (q_bit) begin
      rem_d = gbc_pkg::DIVR_W'(rem_sh - {1'b0, divr_q});
    end else begin
      rem_d = rem_sh[gbc_pkg::DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(gbc_pkg::SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q  <= req_i.dividend[gbc_pkg::SUM_W-1];
      mag_q  <= req_i.dividend[gbc_pkg::SUM_W-1] ? gbc_pkg::SUM_W'(-req_i.dividend)
                                                   : gbc_pkg::SUM_W'(req_i.dividend);
      rem_q  <= '0;
      divr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      mag_q <= {mag_q[gbc_pkg::SUM_W-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(gbc_pkg::SUM_W'(-mag_q)) : $signed(mag_q);

endmodule

// ===== design/gyro_bias_calib_ema_filter.sv =====
// Gyro bias calibration and exponential rate filter, top level.
// Depends on gbc_pkg and gbc_div.
//
//   Channel   Direction  Signals                               Carries
//   cfg       in         cfg_valid_i/ready_o/addr_i/data_i     register writes
//   s_axis    in         tvalid/tready/tdata/tuser             one raw three-axis sample
//   m_axis    out        tvalid/tready/tdata/tuser             filtered rates, done flag
//
// A measurement sample is scaled and filtered; a calibration sample is scaled and
// summed, and one closing the average runs the divider for the new x bias. ST_DONE
// then fills the output register, and the next sample is taken in idle. One 22 x 17
// multiplier is shared by the three scalings and the three filter updates, one axis
// per cycle. Reset loads the register defaults and clears the sequencer, calibration
// and filters. A result waits in the output register while the next sample is
// already taken; the sequencer only stalls while that register is full and unread.
`timescale 1ns / 1ps

module gyro_bias_calib_ema_filter #(
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_rate_x [15:0], raw_rate_y [31:16], raw_rate_z [47:32]
  input  logic [0:0]  s_axis_tuser,   // mode [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // rate_x [19:0], rate_y [39:20], rate_z [59:40], zero [63:60]
  output logic [0:0]  m_axis_tuser    // calib_done [0]
);

  localparam int SCALE_SHIFT = gbc_pkg::INV_W - RATE_FRAC_BITS;
  localparam int RW = gbc_pkg::RATE_W;
  localparam int WW = gbc_pkg::WIDE_W;

  // Configuration registers.
  logic [gbc_pkg::INV_W-1:0]   inv_q;
  logic [gbc_pkg::ALPHA_W-1:0] alpha_q;
  logic [gbc_pkg::CNT_W-1:0]   calib_n_q;

  // Sequencer and data state.
  gbc_pkg::state_e               state_q, state_d;
  logic [1:0]                    idx_q;
  logic                          mode_q;
  logic signed [gbc_pkg::RAW_W-1:0] raw_q [3];
  logic signed [RW-1:0]          scaled_q [3];
  logic signed [RW-1:0]          filt_q [3];
  logic signed [RW-1:0]          bias_x_q;
  logic signed [gbc_pkg::SUM_W-1:0] sum_q;
  logic [gbc_pkg::CNT_W-1:0]     cnt_q;
  logic                          done_flag_q;

  logic                          out_valid_q;
  logic [3*RW-1:0]               out_data_q;
  logic                          out_done_q;

  // Shared datapath.
  logic [gbc_pkg::ALPHA_W-1:0]   alpha_eff;
  logic signed [RW:0]            diff;
  logic signed [21:0]            mul_a;
  logic signed [16:0]            mul_b;
  logic signed [38:0]            prod;
  logic signed [WW-1:0]          prod_ext;
  logic signed [WW-1:0]          ema_acc;
  logic signed [RW-1:0]          scale_res;
  logic signed [RW-1:0]          ema_res;
  logic signed [RW-1:0]          bias_res;
  logic signed [gbc_pkg::SUM_W-1:0] sum_new;
  logic [gbc_pkg::CNT_W-1:0]     cnt_new;
  logic                          calib_hit;
  logic                          out_free;
  logic                          in_fire;

  gbc_pkg::div_req_t             div_req;
  logic                          div_done;
  logic signed [gbc_pkg::SUM_W-1:0] div_quot;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == gbc_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= gbc_pkg::INV_W'(3996);
      alpha_q   <= gbc_pkg::ALPHA_W'(51);
      calib_n_q <= gbc_pkg::CNT_W'(200);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        gbc_pkg::REG_INV_SENS:  inv_q     <= cfg_data_i[gbc_pkg::INV_W-1:0];
        gbc_pkg::REG_ALPHA:     alpha_q   <= cfg_data_i[gbc_pkg::ALPHA_W-1:0];
        gbc_pkg::REG_CALIB_CNT: calib_n_q <= cfg_data_i[gbc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The filter update a*s + (256-a)*p is computed as 256*p + a*(s-p), so one
  // multiply per axis suffices.
  always_comb begin
    alpha_eff = (alpha_q > gbc_pkg::ALPHA_ONE) ? gbc_pkg::ALPHA_ONE : alpha_q;
    diff      = (RW+1)'(scaled_q[idx_q]) - (RW+1)'(filt_q[idx_q]);
    if (state_q == gbc_pkg::ST_EMA) begin
      mul_a = 22'(diff);
      mul_b = $signed({8'd0, alpha_eff});
    end else begin
      mul_a = 22'(raw_q[idx_q]);
      mul_b = $signed({1'b0, inv_q});
    end
    prod      = mul_a * mul_b;
    prod_ext  = WW'(prod);
    scale_res = gbc_pkg::sat_rate(prod_ext >>> SCALE_SHIFT);
    ema_acc   = $signed({{(WW-RW-gbc_pkg::EMA_SHIFT){filt_q[idx_q][RW-1]}}, filt_q[idx_q],
                         {gbc_pkg::EMA_SHIFT{1'b0}}})
                + prod_ext + WW'(128);
    ema_res   = gbc_pkg::sat_rate(ema_acc >>> gbc_pkg::EMA_SHIFT);
    bias_res  = gbc_pkg::sat_rate(WW'(scaled_q[0]) - WW'(bias_x_q));
    sum_new   = sum_q + gbc_pkg::SUM_W'(scaled_q[0]);
    cnt_new   = cnt_q + gbc_pkg::CNT_W'(1);
    // A wrapped count stands for 1024 samples.
    calib_hit = (cnt_new == '0) || (cnt_new >= calib_n_q);
  end

  always_comb begin
    div_req.start    = (state_q == gbc_pkg::ST_ACCUM) && calib_hit;
    div_req.dividend = sum_new;
    div_req.divisor  = (cnt_new == '0) ? gbc_pkg::DIVR_W'(1024) : {1'b0, cnt_new};
  end

  gbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbc_pkg::ST_IDLE: begin
        if (in_fire) state_d = gbc_pkg::ST_SCALE;
      end
      gbc_pkg::ST_SCALE: begin
        if (idx_q == 2'd2) state_d = mode_q ? gbc_pkg::ST_BIAS : gbc_pkg::ST_ACCUM;
      end
      gbc_pkg::ST_BIAS:  state_d = gbc_pkg::ST_EMA;
      gbc_pkg::ST_EMA: begin
        if (idx_q == 2'd2) state_d = gbc_pkg::ST_DONE;
      end
      gbc_pkg::ST_ACCUM: state_d = calib_hit ? gbc_pkg::ST_DIV : gbc_pkg::ST_DONE;
      gbc_pkg::ST_DIV: begin
        if (div_done) state_d = gbc_pkg::ST_DONE;
      end
      gbc_pkg::ST_DONE: begin
        if (out_free) state_d = gbc_pkg::ST_IDLE;
      end
      default: state_d = gbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      done_flag_q <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      bias_x_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        filt_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == gbc_pkg::ST_SCALE) || (state_q == gbc_pkg::ST_EMA)) begin
        idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end else begin
        idx_q <= '0;
      end

      case (state_q)
        gbc_pkg::ST_IDLE: begin
          if (in_fire) done_flag_q <= 1'b0;
        end
        gbc_pkg::ST_EMA: filt_q[idx_q] <= ema_res;
        gbc_pkg::ST_ACCUM: begin
          done_flag_q <= calib_hit;
          if (calib_hit) begin
            sum_q <= '0;
            cnt_q <= '0;
          end else begin
            sum_q <= sum_new;
            cnt_q <= cnt_new;
          end
        end
        gbc_pkg::ST_DIV: begin
          if (div_done) bias_x_q <= gbc_pkg::sat_rate(WW'(div_quot));
        end
        default: ;
      endcase

      if ((state_q == gbc_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= s_axis_tuser[0];
      raw_q[0] <= s_axis_tdata[15:0];
      raw_q[1] <= s_axis_tdata[31:16];
      raw_q[2] <= s_axis_tdata[47:32];
    end
    if (state_q == gbc_pkg::ST_SCALE) scaled_q[idx_q] <= scale_res;
    if (state_q == gbc_pkg::ST_BIAS)  scaled_q[0]     <= bias_res;
    if ((state_q == gbc_pkg::ST_DONE) && out_free) begin
      out_data_q <= {filt_q[2], filt_q[1], filt_q[0]};
      out_done_q <= done_flag_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};
  assign m_axis_tuser  = out_done_q;

endmodule

// ===== tb/sv/tb_gyro_bias_calib_ema_filter.sv =====
// Self-checking testbench for gyro_bias_calib_ema_filter: raw three-axis samples go in,
// and every filtered result is compared against a local model of the calibration and filter.
// Depends on gbc_pkg and the RTL of gyro_bias_calib_ema_filter.
`timescale 1ns / 1ps

module tb_gyro_bias_calib_ema_filter;

  localparam int FRAC_BITS   = 8;
  localparam int SCALE_SHIFT = 16 - FRAC_BITS;
  localparam int DRAIN_CYCLES = 50;    // longer than a closing calibration sample
  localparam int STALL_LIMIT  = 5000;  // cycles without any transaction before giving up
  localparam int MAX_REPORTS  = 10;

  localparam logic MODE_CALIB   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  // Index 3 is not a register; writes to it must change nothing.
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] raw_z;
    logic [15:0] raw_y;
    logic [15:0] raw_x;
  } gyro_sample_t;

  typedef struct packed {
    logic              calib_done;
    logic signed [19:0] rate_z;
    logic signed [19:0] rate_y;
    logic signed [19:0] rate_x;
  } rate_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  gyro_bias_calib_ema_filter #(
    .RATE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Register mirror and calibration/filter state, all at their reset values.
  logic [15:0]        inv_sens     = 16'd3996;
  logic [8:0]         alpha        = 9'd51;
  logic [9:0]         calib_target = 10'd200;
  longint             cal_sum      = 0;
  int                 cal_count    = 0;
  logic signed [19:0] x_bias       = '0;
  logic signed [19:0] flt_x        = '0;
  logic signed [19:0] flt_y        = '0;
  logic signed [19:0] flt_z        = '0;

  gyro_sample_t pending_samples[$];
  rate_result_t rates_due[$];
  int           mismatches = 0;

  function automatic logic signed [19:0] clamp20(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic logic signed [19:0] to_dps(input logic signed [15:0] raw);
    longint prod;
    prod = longint'(raw) * longint'(inv_sens);
    return clamp20(prod >>> SCALE_SHIFT);
  endfunction

  function automatic logic signed [19:0] smooth(input logic signed [19:0] prev,
                                                 input logic signed [19:0] smp);
    longint w;
    longint acc;
    w   = (alpha > 9'd256) ? 256 : longint'(alpha);
    acc = w * longint'(smp) + (256 - w) * longint'(prev) + 128;
    return clamp20(acc >>> 8);
  endfunction

  // Advances the calibration and filter state by one sample and returns its result.
  function automatic rate_result_t calc_rates(input gyro_sample_t smp);
    rate_result_t       res;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic signed [19:0] sz;
    longint             n;
    sx = to_dps(smp.raw_x);
    sy = to_dps(smp.raw_y);
    sz = to_dps(smp.raw_z);
    res.calib_done = 1'b0;
    if (smp.mode == MODE_CALIB) begin
      cal_sum   += longint'(sx);
      cal_count = (cal_count + 1) % 1024;
      if (cal_count == 0 || cal_count >= int'(calib_target)) begin
        n          = (cal_count == 0) ? 1024 : longint'(cal_count);
        x_bias     = clamp20(cal_sum / n);
        cal_sum    = 0;
        cal_count  = 0;
        res.calib_done = 1'b1;
      end
    end else begin
      flt_x = smooth(flt_x, clamp20(longint'(sx) - longint'(x_bias)));
      flt_y = smooth(flt_y, sy);
      flt_z = smooth(flt_z, sz);
    end
    res.rate_x = flt_x;
    res.rate_y = flt_y;
    res.rate_z = flt_z;
    return res;
  endfunction

  // Sender: bursts of random or fixed length, with or without random gaps, valid held until taken.
  gyro_sample_t drv_sample;
  int           burst_left = 0;
  int           gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        drv_sample = pending_samples.pop_front();
        s_axis_tdata  <= {drv_sample.raw_z, drv_sample.raw_y, drv_sample.raw_x};
        s_axis_tuser  <= drv_sample.mode;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          case ($urandom_range(0, 7))
            0: begin burst_left = 150; gap_left = 0; end
            1, 2: begin burst_left = $urandom_range(1, 24); gap_left = 0; end
            3: begin burst_left = $urandom_range(1, 24); gap_left = $urandom_range(10, 40); end
            default: begin burst_left = $urandom_range(1, 24); gap_left = $urandom_range(1, 6); end
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, random, alternating and long stalls.
  int ready_style = 0;
  int ready_span  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_style = 0;
      ready_span  = 0;
    end else begin
      if (ready_span == 0) begin
        ready_style = $urandom_range(0, 3);
        ready_span  = $urandom_range(20, 300);
      end else begin
        ready_span--;
      end
      case (ready_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ~m_axis_tready;
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Monitor: checks results, predicts from accepted samples, mirrors register writes.
  rate_result_t seen;
  rate_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.rate_x     = m_axis_tdata[19:0];
        seen.rate_y     = m_axis_tdata[39:20];
        seen.rate_z     = m_axis_tdata[59:40];
        seen.calib_done = m_axis_tuser[0];
        if (rates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: x=%0d y=%0d z=%0d done=%0b",
                     seen.rate_x, seen.rate_y, seen.rate_z, seen.calib_done);
        end else begin
          want = rates_due.pop_front();
          if (seen.rate_x !== want.rate_x || seen.rate_y !== want.rate_y ||
              seen.rate_z !== want.rate_z || seen.calib_done !== want.calib_done ||
              m_axis_tdata[63:60] !== 4'd0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("rate mismatch: exp x=%0d y=%0d z=%0d done=%0b pad=0,",
                       want.rate_x, want.rate_y, want.rate_z, want.calib_done,
                       " got x=%0d y=%0d z=%0d done=%0b pad=%0h",
                       seen.rate_x, seen.rate_y, seen.rate_z, seen.calib_done,
                       m_axis_tdata[63:60]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rates_due.push_back(calc_rates({s_axis_tuser[0], s_axis_tdata}));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          gbc_pkg::REG_INV_SENS:  inv_sens     = cfg_data_i;
          gbc_pkg::REG_ALPHA:     alpha        = cfg_data_i[8:0];
          gbc_pkg::REG_CALIB_CNT: calib_target = cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_sample(input logic mode, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    pending_samples.push_back('{mode: mode, raw_z: z, raw_y: y, raw_x: x});
  endtask

  // Returns once every queued sample is taken and every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || rates_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  int          calib_pct;
  int          n_items;
  logic        mode;
  logic [15:0] cfg_val;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: field extremes, then a calibration left open under measurements.
    add_sample(MODE_MEASURE, 16'h7FFF, 16'h8000, 16'h0000);
    add_sample(MODE_MEASURE, 16'h8000, 16'h7FFF, 16'hFFFF);
    add_sample(MODE_MEASURE, 16'h0001, 16'hFFFF, 16'h5555);
    add_sample(MODE_MEASURE, 16'h0000, 16'h0000, 16'hAAAA);
    add_sample(MODE_CALIB, 16'h7FFF, 16'h1234, 16'h8000);
    add_sample(MODE_CALIB, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_sample(MODE_MEASURE, 16'h0100, 16'hFF00, 16'h0080);
    wait_idle();

    // Full gain, alpha above one, sample count lowered below the running count.
    write_reg(gbc_pkg::REG_INV_SENS, 16'hFFFF);
    write_reg(gbc_pkg::REG_ALPHA, 16'h01FF);
    write_reg(gbc_pkg::REG_CALIB_CNT, 16'hFC01);
    add_sample(MODE_CALIB, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_sample(MODE_MEASURE, 16'h8000, 16'h8000, 16'h8000);
    add_sample(MODE_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    wait_idle();

    // Zero gain, zero alpha (filters hold), zero sample count.
    write_reg(gbc_pkg::REG_INV_SENS, 16'h0000);
    write_reg(gbc_pkg::REG_ALPHA, 16'h0000);
    write_reg(gbc_pkg::REG_CALIB_CNT, 16'h0000);
    add_sample(MODE_CALIB, 16'h8000, 16'h8000, 16'h8000);
    add_sample(MODE_MEASURE, 16'h3039, 16'hCFC7, 16'h7FFF);
    wait_idle();

    // Most negative bias, with a measurement in the middle of the average.
    write_reg(gbc_pkg::REG_INV_SENS, 16'hFFFF);
    write_reg(gbc_pkg::REG_ALPHA, 16'd128);
    write_reg(gbc_pkg::REG_CALIB_CNT, 16'd4);
    write_reg(REG_NONE, 16'hFFFF);
    add_sample(MODE_CALIB, 16'h8000, 16'h0000, 16'h0000);
    add_sample(MODE_CALIB, 16'h8000, 16'h0000, 16'h0000);
    add_sample(MODE_MEASURE, 16'h1000, 16'h2000, 16'h3000);
    add_sample(MODE_CALIB, 16'h8000, 16'h0000, 16'h0000);
    add_sample(MODE_CALIB, 16'h8000, 16'h0000, 16'h0000);
    add_sample(MODE_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_sample(MODE_MEASURE, 16'hFFFF, 16'h0001, 16'hFFFF);

    // Random phases; the last one runs the largest sample count to completion.
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: cfg_val = 16'h0000;
        1: cfg_val = 16'hFFFF;
        2: cfg_val = 16'd3996;
        default: cfg_val = 16'($urandom);
      endcase
      write_reg(gbc_pkg::REG_INV_SENS, cfg_val);
      case ($urandom_range(0, 4))
        0: cfg_val = 16'd0;
        1: cfg_val = 16'd256;
        2: cfg_val = 16'($urandom_range(257, 511));
        3: cfg_val = 16'($urandom);
        default: cfg_val = 16'($urandom_range(1, 255));
      endcase
      write_reg(gbc_pkg::REG_ALPHA, cfg_val);
      if (ph == 8) begin
        cfg_val = 16'd1023;
      end else begin
        case ($urandom_range(0, 5))
          0: cfg_val = 16'd0;
          1: cfg_val = 16'($urandom);
          default: cfg_val = 16'($urandom_range(1, 12));
        endcase
      end
      write_reg(gbc_pkg::REG_CALIB_CNT, cfg_val);

      n_items   = (ph == 8) ? 1100 : 100;
      calib_pct = (ph == 8) ? 97 : $urandom_range(15, 80);
      for (int i = 0; i < n_items; i++) begin
        mode = ($urandom_range(0, 99) < calib_pct) ? MODE_CALIB : MODE_MEASURE;
        add_sample(mode, rand_raw(), rand_raw(), rand_raw());
        // Now and then let everything drain before sending more.
        if (i % 25 == 24 && $urandom_range(0, 2) == 0)
          wait_idle();
      end
    end

    wait_idle();
    if (mismatches == 0 && rates_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
